/* sv/yuv2rgb_pkg.sv */
`default_nettype none

package yuv2rgb_pkg;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int CHROMA_W  = 9;
    localparam int COEF_W    = 12;
    localparam int FRAC_BITS = 10;
    localparam int SUM_W     = 22;
    localparam int RGB_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_R_CR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_G_CB = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_G_CR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B_CB = 3'd3;

    // Q2.10 coefficient defaults
    localparam logic [COEF_W-1:0] COEF_R_CR_RST = 12'd1441;
    localparam logic [COEF_W-1:0] COEF_G_CB_RST = 12'd354;
    localparam logic [COEF_W-1:0] COEF_G_CR_RST = 12'd734;
    localparam logic [COEF_W-1:0] COEF_B_CB_RST = 12'd1842;

    // Saturation limit of one 8-bit channel
    localparam logic [PIX_W-1:0] CHAN_MAX = 8'hff;

    // Q.10 weighted sum of one channel, wide enough for all products
    typedef logic signed [SUM_W-1:0] sum_t;

    // Centered chroma sample
    typedef logic signed [CHROMA_W-1:0] chroma_t;

endpackage

`default_nettype wire

/* sv/yuv2rgb_pack.sv */
`default_nettype none

module yuv2rgb_pack (
    input  yuv2rgb_pkg::sum_t              sum_r,
    input  yuv2rgb_pkg::sum_t              sum_g,
    input  yuv2rgb_pkg::sum_t              sum_b,
    output logic [yuv2rgb_pkg::RGB_W-1:0]  pixel
);
    import yuv2rgb_pkg::*;

    logic [PIX_W-1:0] chan_r;
    logic [PIX_W-1:0] chan_g;
    logic [PIX_W-1:0] chan_b;

    // Floor to integer, clamp to 0..255
    function automatic logic [PIX_W-1:0] sat_chan(input sum_t sum);
        logic [SUM_W-FRAC_BITS-2:0] whole;
        whole = sum[SUM_W-2:FRAC_BITS];
        if (sum[SUM_W-1]) begin
            sat_chan = '0;
        end else if (|whole[SUM_W-FRAC_BITS-2:PIX_W]) begin
            sat_chan = CHAN_MAX;
        end else begin
            sat_chan = whole[PIX_W-1:0];
        end
    endfunction

    always_comb begin
        chan_r = sat_chan(sum_r);
        chan_g = sat_chan(sum_g);
        chan_b = sat_chan(sum_b);
    end

    // Pack as 5:6:5
    assign pixel = {chan_r[7:3], chan_g[7:2], chan_b[7:3]};

endmodule

`default_nettype wire

/* sv/yuyv_to_rgb565_converter.sv */
`default_nettype none

// YUYV 4:2:2 to RGB565 converter. Each request is one macropixel (Y0, Cb,
// Y1, Cr plus an end-of-frame flag) and yields one result with two RGB565
// pixels that share the chroma. The datapath is a four-stage pipeline:
// chroma centering, the four coefficient multiplies, the per-pixel sums,
// and saturate/pack into the output register. It takes one macropixel every
// clock unless back-pressure from the m_ side stalls it. A result passes
// through the stage 1, stage 2, stage 3 and output registers to m_valid.
// Back-pressure on the m_ side propagates stage by stage, so bubbles are
// squeezed out and nothing is dropped. The four Q2.10 coefficients are
// written through the cfg_ port (index 0..3, other indexes ignored) and
// should only change while the pipeline is empty.
module yuyv_to_rgb565_converter (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [yuv2rgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [yuv2rgb_pkg::COEF_W-1:0]        cfg_data,

    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [yuv2rgb_pkg::PIX_W-1:0]         s_y_first,
    input  wire logic [yuv2rgb_pkg::PIX_W-1:0]         s_chroma_blue,
    input  wire logic [yuv2rgb_pkg::PIX_W-1:0]         s_y_second,
    input  wire logic [yuv2rgb_pkg::PIX_W-1:0]         s_chroma_red,
    input  wire logic                                  s_end_of_frame,

    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [yuv2rgb_pkg::RGB_W-1:0]              m_pixel_first,
    output logic [yuv2rgb_pkg::RGB_W-1:0]              m_pixel_second,
    output logic                                       m_frame_end
);
    import yuv2rgb_pkg::*;

    // Coefficient registers
    logic [COEF_W-1:0] coef_r_cr_reg;
    logic [COEF_W-1:0] coef_g_cb_reg;
    logic [COEF_W-1:0] coef_g_cr_reg;
    logic [COEF_W-1:0] coef_b_cb_reg;

    // Stage 1: luma and centered chroma
    logic             st1_valid_reg;
    logic [PIX_W-1:0] st1_y0_reg;
    logic [PIX_W-1:0] st1_y1_reg;
    chroma_t          st1_u_reg;
    chroma_t          st1_v_reg;
    logic             st1_eof_reg;
    chroma_t          st1_u_next;
    chroma_t          st1_v_next;

    // Stage 2: products
    logic             st2_valid_reg;
    logic [PIX_W-1:0] st2_y0_reg;
    logic [PIX_W-1:0] st2_y1_reg;
    sum_t             st2_r_cr_reg;
    sum_t             st2_g_cb_reg;
    sum_t             st2_g_cr_reg;
    sum_t             st2_b_cb_reg;
    logic             st2_eof_reg;
    sum_t             st2_r_cr_next;
    sum_t             st2_g_cb_next;
    sum_t             st2_g_cr_next;
    sum_t             st2_b_cb_next;

    // Stage 3: per-pixel channel sums
    logic             st3_valid_reg;
    sum_t             st3_r0_reg;
    sum_t             st3_g0_reg;
    sum_t             st3_b0_reg;
    sum_t             st3_r1_reg;
    sum_t             st3_g1_reg;
    sum_t             st3_b1_reg;
    logic             st3_eof_reg;
    sum_t             base0;
    sum_t             base1;

    // Stage 4: output register
    logic             out_valid_reg;
    logic [RGB_W-1:0] out_pix0_reg;
    logic [RGB_W-1:0] out_pix1_reg;
    logic             out_eof_reg;
    logic [RGB_W-1:0] out_pix0_next;
    logic [RGB_W-1:0] out_pix1_next;

    // Stage enables
    logic st1_ready;
    logic st2_ready;
    logic st3_ready;
    logic out_ready;

    assign out_ready = !out_valid_reg || m_ready;
    assign st3_ready = !st3_valid_reg || out_ready;
    assign st2_ready = !st2_valid_reg || st3_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign s_ready   = st1_ready;
    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_r_cr_reg <= COEF_R_CR_RST;
            coef_g_cb_reg <= COEF_G_CB_RST;
            coef_g_cr_reg <= COEF_G_CR_RST;
            coef_b_cb_reg <= COEF_B_CB_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_COEF_R_CR: coef_r_cr_reg <= cfg_data;
                CFG_COEF_G_CB: coef_g_cb_reg <= cfg_data;
                CFG_COEF_G_CR: coef_g_cr_reg <= cfg_data;
                CFG_COEF_B_CB: coef_b_cb_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (st1_ready) begin
                st1_valid_reg <= s_valid;
            end
            if (st2_ready) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (st3_ready) begin
                st3_valid_reg <= st2_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= st3_valid_reg;
            end
        end
    end

    // Center chroma: subtracting 128 flips the top bit, then sign-extend
    always_comb begin
        st1_u_next = $signed({~s_chroma_blue[PIX_W-1], ~s_chroma_blue[PIX_W-1],
                              s_chroma_blue[PIX_W-2:0]});
        st1_v_next = $signed({~s_chroma_red[PIX_W-1], ~s_chroma_red[PIX_W-1],
                              s_chroma_red[PIX_W-2:0]});
    end

    always_ff @(posedge aclk) begin
        if (st1_ready && s_valid) begin
            st1_y0_reg  <= s_y_first;
            st1_y1_reg  <= s_y_second;
            st1_u_reg   <= st1_u_next;
            st1_v_reg   <= st1_v_next;
            st1_eof_reg <= s_end_of_frame;
        end
    end

    // Coefficient multiplies
    always_comb begin
        st2_r_cr_next = $signed({1'b0, coef_r_cr_reg}) * st1_v_reg;
        st2_g_cb_next = $signed({1'b0, coef_g_cb_reg}) * st1_u_reg;
        st2_g_cr_next = $signed({1'b0, coef_g_cr_reg}) * st1_v_reg;
        st2_b_cb_next = $signed({1'b0, coef_b_cb_reg}) * st1_u_reg;
    end

    always_ff @(posedge aclk) begin
        if (st2_ready && st1_valid_reg) begin
            st2_y0_reg   <= st1_y0_reg;
            st2_y1_reg   <= st1_y1_reg;
            st2_r_cr_reg <= st2_r_cr_next;
            st2_g_cb_reg <= st2_g_cb_next;
            st2_g_cr_reg <= st2_g_cr_next;
            st2_b_cb_reg <= st2_b_cb_next;
            st2_eof_reg  <= st1_eof_reg;
        end
    end

    // Sum luma and chroma terms per pixel
    assign base0 = $signed({{(SUM_W-PIX_W-FRAC_BITS){1'b0}}, st2_y0_reg, {FRAC_BITS{1'b0}}});
    assign base1 = $signed({{(SUM_W-PIX_W-FRAC_BITS){1'b0}}, st2_y1_reg, {FRAC_BITS{1'b0}}});

    always_ff @(posedge aclk) begin
        if (st3_ready && st2_valid_reg) begin
            st3_r0_reg  <= base0 + st2_r_cr_reg;
            st3_g0_reg  <= base0 - st2_g_cb_reg - st2_g_cr_reg;
            st3_b0_reg  <= base0 + st2_b_cb_reg;
            st3_r1_reg  <= base1 + st2_r_cr_reg;
            st3_g1_reg  <= base1 - st2_g_cb_reg - st2_g_cr_reg;
            st3_b1_reg  <= base1 + st2_b_cb_reg;
            st3_eof_reg <= st2_eof_reg;
        end
    end

    // Saturate and pack both pixels
    yuv2rgb_pack u_pack_first (
        .sum_r (st3_r0_reg),
        .sum_g (st3_g0_reg),
        .sum_b (st3_b0_reg),
        .pixel (out_pix0_next)
    );

    yuv2rgb_pack u_pack_second (
        .sum_r (st3_r1_reg),
        .sum_g (st3_g1_reg),
        .sum_b (st3_b1_reg),
        .pixel (out_pix1_next)
    );

    always_ff @(posedge aclk) begin
        if (out_ready && st3_valid_reg) begin
            out_pix0_reg <= out_pix0_next;
            out_pix1_reg <= out_pix1_next;
            out_eof_reg  <= st3_eof_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_pixel_first  = out_pix0_reg;
    assign m_pixel_second = out_pix1_reg;
    assign m_frame_end    = out_eof_reg;

    // Accepted request lands in stage 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> st1_valid_reg)
        else $error("accepted request missing from stage 1");

    // Stage 1 holds its item while stage 2 is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !st2_ready |=> st1_valid_reg && $stable(st1_u_reg)
                                         && $stable(st1_v_reg))
        else $error("stage 1 lost or changed a stalled item");

    // Output register empties on reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
